// ===== src/scf_pkg.sv =====
`timescale 1ns / 1ps

package scf_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] SEED_RESET = 16'hFFFF;
  localparam logic [1:0]  SKIP_RESET = 2'd2;

  localparam logic [7:0] CHAR_STAR    = 8'h2A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [0:0] REG_SKIP_COUNT = 1'b0;
  localparam logic [0:0] REG_CRC_SEED   = 1'b1;

  // Trailer items still to send after the last sentence byte
  localparam logic [2:0] TRL_STAR  = 3'd6;
  localparam logic [2:0] TRL_HEX3  = 3'd5;
  localparam logic [2:0] TRL_HEX2  = 3'd4;
  localparam logic [2:0] TRL_HEX1  = 3'd3;
  localparam logic [2:0] TRL_HEX0  = 3'd2;
  localparam logic [2:0] TRL_NL    = 3'd1;
  localparam logic [2:0] TRL_NONE  = 3'd0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // One byte of CRC-16, polynomial 0x1021, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10) begin
      d = 8'h30 + {4'h0, n};
    end else begin
      d = 8'h37 + {4'h0, n};
    end
    return d;
  endfunction

endpackage

// ===== src/sentence_crc16_trailer_framer_unit.sv =====
`timescale 1ns / 1ps
// Sentence CRC-16 trailer framer.
// Input channel (in_valid/in_ready/in_data) takes one sentence character per
// transfer; in_last marks the final character. Every character is passed to
// the output channel (out_valid/out_ready/out_data) in the cycle after its
// transfer. After the last character the block appends '*', the CRC-16
// (poly 0x1021, MSB first) as four uppercase hex digits and a newline; only
// the newline carries out_last. The first skip_count characters of each
// sentence are left out of the CRC, which starts from crc_seed.
// Throughput: one character per cycle while out_ready is high; after a last
// character in_ready stays low until the trailer ('*', four hex digits and
// newline) has been sent from the single output register.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready:
// index 0 writes skip_count, index 1 writes crc_seed (used at next sentence).
// Reset (synchronous, rst high) restores skip_count 2, seed 0xFFFF and drops
// any pending output. When the receiver stalls, the output register holds
// and in_ready falls in the same cycle.
module sentence_crc16_trailer_framer_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  scf_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output scf_pkg::out_t   out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [0:0]      cfg_index,
  input  logic [15:0]     cfg_data
);

  logic [1:0]  skip_count;
  logic [15:0] crc_seed;
  logic [15:0] crc_value;
  logic [1:0]  prefix_position;
  logic        in_sentence;
  logic [2:0]  trailer_count;
  logic [15:0] trailer_crc;

  logic        slot_free;
  logic        in_fire;
  logic [15:0] crc_base;
  logic [1:0]  pos_base;
  logic [15:0] crc_next;
  logic [1:0]  pos_next;
  scf_pkg::out_t trailer_item;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = slot_free && (trailer_count == scf_pkg::TRL_NONE);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    crc_base = in_sentence ? crc_value : crc_seed;
    pos_base = in_sentence ? prefix_position : 2'd0;
    if (pos_base < skip_count) begin
      pos_next = pos_base + 2'd1;
      crc_next = crc_base;
    end else begin
      pos_next = pos_base;
      crc_next = scf_pkg::crc_byte(crc_base, in_data.in_byte);
    end
  end

  always_comb begin
    trailer_item.out_last = 1'b0;
    case (trailer_count)
      scf_pkg::TRL_STAR: trailer_item.out_byte = scf_pkg::CHAR_STAR;
      scf_pkg::TRL_HEX3: trailer_item.out_byte = scf_pkg::hex_digit(trailer_crc[15:12]);
      scf_pkg::TRL_HEX2: trailer_item.out_byte = scf_pkg::hex_digit(trailer_crc[11:8]);
      scf_pkg::TRL_HEX1: trailer_item.out_byte = scf_pkg::hex_digit(trailer_crc[7:4]);
      scf_pkg::TRL_HEX0: trailer_item.out_byte = scf_pkg::hex_digit(trailer_crc[3:0]);
      scf_pkg::TRL_NL: begin
        trailer_item.out_byte = scf_pkg::CHAR_NEWLINE;
        trailer_item.out_last = 1'b1;
      end
      default: trailer_item.out_byte = scf_pkg::CHAR_NEWLINE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count <= scf_pkg::SKIP_RESET;
      crc_seed   <= scf_pkg::SEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scf_pkg::REG_SKIP_COUNT: skip_count <= cfg_data[1:0];
        scf_pkg::REG_CRC_SEED:   crc_seed   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_value       <= scf_pkg::SEED_RESET;
      prefix_position <= 2'd0;
      in_sentence     <= 1'b0;
      trailer_count   <= scf_pkg::TRL_NONE;
      out_valid       <= 1'b0;
    end else begin
      if (in_fire) begin
        out_valid         <= 1'b1;
        out_data.out_byte <= in_data.in_byte;
        out_data.out_last <= 1'b0;
        if (in_data.in_last) begin
          // close the sentence and queue the trailer
          in_sentence     <= 1'b0;
          prefix_position <= 2'd0;
          crc_value       <= crc_seed;
          trailer_crc     <= crc_next;
          trailer_count   <= scf_pkg::TRL_STAR;
        end else begin
          in_sentence     <= 1'b1;
          prefix_position <= pos_next;
          crc_value       <= crc_next;
        end
      end else if (slot_free) begin
        if (trailer_count != scf_pkg::TRL_NONE) begin
          out_valid     <= 1'b1;
          out_data      <= trailer_item;
          trailer_count <= trailer_count - 3'd1;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

endmodule
